// File: rtl/ppm_p6_stream_parser_top_assert.svh
// Assertion macros used by the P6 stream parser module ppsp_parser.
`ifndef PPM_P6_STREAM_PARSER_TOP_ASSERT_SVH
`define PPM_P6_STREAM_PARSER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PPSP_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("ppsp assertion failed");

`define PPSP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppsp assertion failed");

`else

`define PPSP_ASSERT_ALWAYS(label, clk, rst, expr)

`define PPSP_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/ppsp_pkg.sv
// Shared types, codes and constants of the P6 stream parser.
`default_nettype none

package ppsp_pkg;

  localparam int MAX_DIM_DEFAULT = 4096;

  localparam int WORD_W = 17;
  localparam logic [WORD_W-1:0] WORD_CAP = 17'd65536;

  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_END     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [2:0] KIND_PIXEL      = 3'd0;
  localparam logic [2:0] KIND_HEADER     = 3'd1;
  localparam logic [2:0] KIND_BAD_MAGIC  = 3'd2;
  localparam logic [2:0] KIND_BAD_MAXVAL = 3'd3;
  localparam logic [2:0] KIND_TOO_LARGE  = 3'd4;

  localparam logic [7:0] CH_P     = 8'd80;
  localparam logic [7:0] CH_SIX   = 8'd54;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] BYTE_END = 8'd255;

  localparam int TDATA_OUT_W = 80;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } ppsp_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] color;
    logic [23:0] pixel_index;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        last;
  } ppsp_result_t;

endpackage

`default_nettype wire

// File: rtl/ppsp_in_stage.sv
// Input register stage of the P6 stream parser.
`default_nettype none

module ppsp_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  output logic                s_ready,
  input  ppsp_pkg::ppsp_item_t s_item,
  input  logic                advance,
  output logic                in_valid,
  output ppsp_pkg::ppsp_item_t in_item
);
  import ppsp_pkg::*;

  assign s_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_ready) begin
      in_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      in_item <= s_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ppsp_parser.sv
// Header and pixel parsing state with its next-state logic.
`default_nettype none
`include "ppm_p6_stream_parser_top_assert.svh"

module ppsp_parser #(
  parameter int MAX_DIM = ppsp_pkg::MAX_DIM_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  ppsp_pkg::ppsp_item_t   item,
  output logic                  res_valid,
  output ppsp_pkg::ppsp_result_t res
);
  import ppsp_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM + 1);

  typedef enum logic [8:0] {
    PH_MAGIC0 = 9'b000000001,
    PH_MAGIC1 = 9'b000000010,
    PH_SKIP   = 9'b000000100,
    PH_WIDTH  = 9'b000001000,
    PH_HEIGHT = 9'b000010000,
    PH_MAXVAL = 9'b000100000,
    PH_PIXELS = 9'b001000000,
    PH_DONE   = 9'b010000000,
    PH_HALT   = 9'b100000000
  } phase_t;

  phase_t            phase, phase_next;
  logic [WORD_W-1:0] word_value, word_value_next;
  logic              word_ended_digits, word_ended_digits_next;
  logic [WORD_W-1:0] width_reg, width_reg_next;
  logic [WORD_W-1:0] height_reg, height_reg_next;
  logic [1:0]        byte_phase, byte_phase_next;
  logic [15:0]       partial_color, partial_color_next;
  logic [CNT_W-1:0]  column_count, column_count_next;
  logic [CNT_W-1:0]  row_count, row_count_next;
  logic [23:0]       pixel_count, pixel_count_next;

  logic              at_end;
  logic [7:0]        b;
  logic              is_ws;
  logic              is_digit;
  logic [20:0]       word_prod;
  logic [WORD_W-1:0] word_sat;
  logic [WORD_W-1:0] word_fed;
  logic              ended_fed;
  logic              col_last;
  logic              row_last;
  logic              too_large;

  assign at_end   = (item.op == OP_END);
  assign b        = at_end ? BYTE_END : item.data_byte;
  assign is_ws    = at_end || (b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR});
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

  assign word_prod = 21'(word_value) * 21'd10 + 21'(b[3:0]);
  assign word_sat  = (word_prod > 21'(WORD_CAP)) ? WORD_CAP : word_prod[WORD_W-1:0];

  always_comb begin
    word_fed  = word_value;
    ended_fed = word_ended_digits;
    if (is_ws) begin
      word_fed  = '0;
      ended_fed = 1'b0;
    end else if (!word_ended_digits && is_digit) begin
      word_fed = word_sat;
    end else begin
      ended_fed = 1'b1;
    end
  end

  assign col_last  = ((WORD_W'(column_count) + 1'b1) == width_reg);
  assign row_last  = ((WORD_W'(row_count) + 1'b1) == height_reg);
  assign too_large = (width_reg > WORD_W'(MAX_DIM)) || (height_reg > WORD_W'(MAX_DIM));

  always_comb begin
    phase_next             = phase;
    word_value_next        = word_value;
    word_ended_digits_next = word_ended_digits;
    width_reg_next         = width_reg;
    height_reg_next        = height_reg;
    byte_phase_next        = byte_phase;
    partial_color_next     = partial_color;
    column_count_next      = column_count;
    row_count_next         = row_count;
    pixel_count_next       = pixel_count;
    res_valid              = 1'b0;
    res                    = '0;

    if (item.op == OP_RESTART) begin
      phase_next             = PH_MAGIC0;
      word_value_next        = '0;
      word_ended_digits_next = 1'b0;
      width_reg_next         = '0;
      height_reg_next        = '0;
      byte_phase_next        = '0;
      partial_color_next     = '0;
      column_count_next      = '0;
      row_count_next         = '0;
      pixel_count_next       = '0;
    end else if (item.op != OP_UNUSED) begin
      unique case (phase)
        PH_MAGIC0: begin
          if (!at_end && b == CH_P) begin
            phase_next = PH_MAGIC1;
          end else begin
            phase_next = PH_HALT;
            res_valid  = 1'b1;
            res.kind   = KIND_BAD_MAGIC;
          end
        end
        PH_MAGIC1: begin
          if (!at_end && b == CH_SIX) begin
            phase_next = PH_SKIP;
          end else begin
            phase_next = PH_HALT;
            res_valid  = 1'b1;
            res.kind   = KIND_BAD_MAGIC;
          end
        end
        PH_SKIP: begin
          phase_next = PH_WIDTH;
        end
        PH_WIDTH: begin
          word_value_next        = word_fed;
          word_ended_digits_next = ended_fed;
          if (is_ws) begin
            width_reg_next = word_value;
            phase_next     = PH_HEIGHT;
          end
        end
        PH_HEIGHT: begin
          word_value_next        = word_fed;
          word_ended_digits_next = ended_fed;
          if (is_ws) begin
            height_reg_next = word_value;
            phase_next      = PH_MAXVAL;
          end
        end
        PH_MAXVAL: begin
          word_value_next        = word_fed;
          word_ended_digits_next = ended_fed;
          if (is_ws) begin
            res_valid = 1'b1;
            if (word_value != WORD_W'(BYTE_END)) begin
              phase_next = PH_HALT;
              res.kind   = KIND_BAD_MAXVAL;
            end else if (too_large) begin
              phase_next = PH_HALT;
              res.kind   = KIND_TOO_LARGE;
            end else begin
              byte_phase_next    = '0;
              partial_color_next = '0;
              column_count_next  = '0;
              row_count_next     = '0;
              pixel_count_next   = '0;
              res.kind           = KIND_HEADER;
              res.image_width    = width_reg[12:0];
              res.image_height   = height_reg[12:0];
              if (width_reg == '0 || height_reg == '0) begin
                phase_next = PH_DONE;
                res.last   = 1'b1;
              end else begin
                phase_next = PH_PIXELS;
              end
            end
          end
        end
        PH_PIXELS: begin
          if (byte_phase != 2'd2) begin
            partial_color_next = {partial_color[7:0], b};
            byte_phase_next    = byte_phase + 2'd1;
          end else begin
            res_valid          = 1'b1;
            res.kind           = KIND_PIXEL;
            res.color          = {partial_color, b};
            res.pixel_index    = pixel_count;
            res.last           = col_last && row_last;
            byte_phase_next    = '0;
            partial_color_next = '0;
            pixel_count_next   = pixel_count + 24'd1;
            if (col_last && row_last) begin
              phase_next = PH_DONE;
            end else if (col_last) begin
              column_count_next = '0;
              row_count_next    = row_count + 1'b1;
            end else begin
              column_count_next = column_count + 1'b1;
            end
          end
        end
        PH_DONE, PH_HALT: begin
        end
        default: begin
          phase_next = PH_HALT;
        end
      endcase
    end

    if (!advance) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_MAGIC0;
      word_value        <= '0;
      word_ended_digits <= 1'b0;
      width_reg         <= '0;
      height_reg        <= '0;
      byte_phase        <= '0;
      partial_color     <= '0;
      column_count      <= '0;
      row_count         <= '0;
      pixel_count       <= '0;
    end else if (advance) begin
      phase             <= phase_next;
      word_value        <= word_value_next;
      word_ended_digits <= word_ended_digits_next;
      width_reg         <= width_reg_next;
      height_reg        <= height_reg_next;
      byte_phase        <= byte_phase_next;
      partial_color     <= partial_color_next;
      column_count      <= column_count_next;
      row_count         <= row_count_next;
      pixel_count       <= pixel_count_next;
    end
  end

  `PPSP_ASSERT_IMPLIES(a_counts_in_range, clk, rst, phase == PH_PIXELS,
    (WORD_W'(column_count) < width_reg) && (WORD_W'(row_count) < height_reg))
  `PPSP_ASSERT_ALWAYS(a_byte_phase_range, clk, rst, byte_phase != 2'd3)
  `PPSP_ASSERT_IMPLIES(a_pixel_from_pixels, clk, rst, res_valid && res.kind == KIND_PIXEL,
    advance && phase == PH_PIXELS && byte_phase == 2'd2)

endmodule

`default_nettype wire

// File: rtl/ppsp_out_stage.sv
// Output result register of the P6 stream parser.
`default_nettype none

module ppsp_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  ppsp_pkg::ppsp_result_t res,
  output logic                  out_free,
  output logic                  m_valid,
  input  logic                  m_ready,
  output ppsp_pkg::ppsp_result_t m_res
);
  import ppsp_pkg::*;

  assign out_free = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_free) begin
      m_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      m_res <= res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ppm_p6_stream_parser_top.sv
// Top level of the P6 image stream parser.
`default_nettype none

// Parses a binary P6 image fed one byte per item and emits a header-done
// result or an error result, then one packed RGB pixel per three data bytes.
// The block takes one item in every clock cycle while its output is free.
// An item is captured in an input register when it is accepted, and the
// result register is loaded from it once the result register is free.
// s_axis_tready depends combinationally on m_axis_tready through the advance
// condition of the single parsing stage. An end-of-input item counts as the
// byte 255 while pixels are read, and a restart item clears all parser state.

module ppm_p6_stream_parser_top #(
  parameter int MAX_DIM = ppsp_pkg::MAX_DIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // color[23:0], pixel_index[47:24], image_width[60:48], image_height[73:61], zeros
  output logic [ppsp_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // kind[2:0]
  output logic        m_axis_tlast
);
  import ppsp_pkg::*;

  ppsp_item_t   s_item;
  ppsp_item_t   in_item;
  logic         in_valid;
  logic         advance;
  logic         out_free;
  logic         res_valid;
  ppsp_result_t res;
  ppsp_result_t m_res;

  assign s_item.op        = s_axis_tuser;
  assign s_item.data_byte = s_axis_tdata;
  assign advance          = in_valid && out_free;

  ppsp_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_item   (s_item),
    .advance  (advance),
    .in_valid (in_valid),
    .in_item  (in_item)
  );

  ppsp_parser #(
    .MAX_DIM (MAX_DIM)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  ppsp_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .out_free (out_free),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_res    (m_res)
  );

  assign m_axis_tdata = {6'd0, m_res.image_height, m_res.image_width,
                         m_res.pixel_index, m_res.color};
  assign m_axis_tuser = m_res.kind;
  assign m_axis_tlast = m_res.last;

endmodule

`default_nettype wire

// File: tb/ppm_p6_stream_parser_checker.sv
// Checker that predicts and compares every result of the P6 stream parser.
`timescale 1ns / 100ps

module ppm_p6_stream_parser_checker #(
  parameter int MAX_DIM = ppsp_pkg::MAX_DIM_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // data_byte[7:0]
  input  logic [1:0]                       s_axis_tuser,   // op[1:0]
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // color[23:0], pixel_index[47:24], image_width[60:48], image_height[73:61], zeros
  input  logic [ppsp_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  input  logic [2:0]                       m_axis_tuser,   // kind[2:0]
  input  logic                             m_axis_tlast,
  output int                               fail_count,
  output int                               pending
);
  import ppsp_pkg::*;

  localparam int unsigned MAXVAL_OK = 255;
  localparam int unsigned PRINT_CAP = 40;

  typedef enum logic [3:0] {
    ST_MAGIC0, ST_MAGIC1, ST_SKIP, ST_WIDTH, ST_HEIGHT, ST_MAXVAL, ST_PIXELS, ST_DONE, ST_HALT
  } parse_state_t;

  parse_state_t   state;
  int unsigned    word_acc;
  bit             word_stopped;
  int unsigned    width_val;
  int unsigned    height_val;
  int unsigned    byte_slot;
  logic [15:0]    color_part;
  int unsigned    col;
  int unsigned    row;
  logic [23:0]    pixel_no;
  ppsp_result_t   expected_results[$];
  int             errs = 0;
  int             result_no = 0;

  function automatic void clear_parser();
    state        = ST_MAGIC0;
    word_acc     = 0;
    word_stopped = 1'b0;
    width_val    = 0;
    height_val   = 0;
    byte_slot    = 0;
    color_part   = '0;
    col          = 0;
    row          = 0;
    pixel_no     = '0;
  endfunction

  function automatic ppsp_result_t make_result(logic [2:0] kind, logic [23:0] color,
                                               logic [23:0] idx, int unsigned w,
                                               int unsigned h, bit last);
    ppsp_result_t r;
    r.kind         = kind;
    r.color        = color;
    r.pixel_index  = idx;
    r.image_width  = w[12:0];
    r.image_height = h[12:0];
    r.last         = last;
    return r;
  endfunction

  function automatic bit feed_word(bit at_end, logic [7:0] b, output int unsigned val);
    int unsigned nxt;
    val = 0;
    if (at_end || b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
      val          = word_acc;
      word_acc     = 0;
      word_stopped = 1'b0;
      return 1'b1;
    end
    if (!word_stopped && b >= CH_ZERO && b <= CH_NINE) begin
      nxt      = word_acc * 10 + int'(b - CH_ZERO);
      word_acc = (nxt > int'(WORD_CAP)) ? int'(WORD_CAP) : nxt;
    end else begin
      word_stopped = 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit predict_item(ppsp_item_t it, output ppsp_result_t res);
    logic [7:0]  b;
    bit          at_end;
    int unsigned val;
    bit          fin;
    res = '0;
    if (it.op == OP_RESTART) begin
      clear_parser();
      return 1'b0;
    end
    if (it.op == OP_UNUSED) return 1'b0;
    at_end = (it.op == OP_END);
    b      = at_end ? BYTE_END : it.data_byte;
    case (state)
      ST_MAGIC0: begin
        if (!at_end && b == CH_P) begin
          state = ST_MAGIC1;
          return 1'b0;
        end
        state = ST_HALT;
        res   = make_result(KIND_BAD_MAGIC, '0, '0, 0, 0, 1'b0);
        return 1'b1;
      end
      ST_MAGIC1: begin
        if (!at_end && b == CH_SIX) begin
          state = ST_SKIP;
          return 1'b0;
        end
        state = ST_HALT;
        res   = make_result(KIND_BAD_MAGIC, '0, '0, 0, 0, 1'b0);
        return 1'b1;
      end
      ST_SKIP: begin
        state = ST_WIDTH;
        return 1'b0;
      end
      ST_WIDTH: begin
        if (feed_word(at_end, b, val)) begin
          width_val = val;
          state     = ST_HEIGHT;
        end
        return 1'b0;
      end
      ST_HEIGHT: begin
        if (feed_word(at_end, b, val)) begin
          height_val = val;
          state      = ST_MAXVAL;
        end
        return 1'b0;
      end
      ST_MAXVAL: begin
        if (!feed_word(at_end, b, val)) return 1'b0;
        if (val != MAXVAL_OK) begin
          state = ST_HALT;
          res   = make_result(KIND_BAD_MAXVAL, '0, '0, 0, 0, 1'b0);
          return 1'b1;
        end
        if (width_val > MAX_DIM || height_val > MAX_DIM) begin
          state = ST_HALT;
          res   = make_result(KIND_TOO_LARGE, '0, '0, 0, 0, 1'b0);
          return 1'b1;
        end
        byte_slot  = 0;
        color_part = '0;
        col        = 0;
        row        = 0;
        pixel_no   = '0;
        fin        = (width_val == 0 || height_val == 0);
        if (fin) state = ST_DONE;
        else state = ST_PIXELS;
        res = make_result(KIND_HEADER, '0, '0, width_val, height_val, fin);
        return 1'b1;
      end
      ST_PIXELS: begin
        if (byte_slot < 2) begin
          color_part = {color_part[7:0], b};
          byte_slot++;
          return 1'b0;
        end
        fin        = (col + 1 == width_val && row + 1 == height_val);
        res        = make_result(KIND_PIXEL, {color_part, b}, pixel_no, 0, 0, fin);
        byte_slot  = 0;
        color_part = '0;
        pixel_no   = pixel_no + 24'd1;
        if (fin) begin
          state = ST_DONE;
        end else if (col + 1 >= width_val) begin
          col = 0;
          row++;
        end else begin
          col++;
        end
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(string msg);
    errs++;
    if (errs <= PRINT_CAP) $display("result %0d: %s", result_no, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    ppsp_item_t   cur_item;
    ppsp_result_t want;
    if (rst) begin
      clear_parser();
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        cur_item.op        = s_axis_tuser;
        cur_item.data_byte = s_axis_tdata;
        if (predict_item(cur_item, want)) expected_results.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_no++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("arrived with nothing expected, kind %0d", m_axis_tuser));
        end else begin
          want = expected_results.pop_front();
          check_field("kind", m_axis_tuser, want.kind);
          check_field("color", m_axis_tdata[23:0], want.color);
          check_field("pixel_index", m_axis_tdata[47:24], want.pixel_index);
          check_field("image_width", m_axis_tdata[60:48], want.image_width);
          check_field("image_height", m_axis_tdata[73:61], want.image_height);
          check_field("last", m_axis_tlast, want.last);
          check_field("padding", m_axis_tdata[TDATA_OUT_W-1:74], '0);
        end
      end
    end
    pending    <= expected_results.size();
    fail_count <= errs;
  end

endmodule

// File: tb/ppm_p6_stream_parser_top_test.sv
// Testbench top that feeds P6 files to the stream parser and gives the verdict.
`timescale 1ns / 100ps

module ppm_p6_stream_parser_top_test;
  import ppsp_pkg::*;

  localparam int MAX_DIM     = MAX_DIM_DEFAULT;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = OP_DATA;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic [2:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  int check_failures;
  int results_pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  ppsp_item_t file_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ppm_p6_stream_parser_top #(.MAX_DIM(MAX_DIM)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  ppm_p6_stream_parser_checker #(.MAX_DIM(MAX_DIM)) parse_checker (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .fail_count(check_failures),
    .pending(results_pending)
  );

  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      m_axis_tready <= 1'b0;
      hold_served   <= hold_served + 1;
      hold_left     <= HOLD_CYCLES;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ppm_p6_stream_parser_top_test NOT OK");
        $finish;
      end
    end
  end

  function automatic void add_byte(logic [1:0] op, logic [7:0] b);
    ppsp_item_t it;
    it.op        = op;
    it.data_byte = b;
    file_q.push_back(it);
  endfunction

  function automatic void add_separator();
    int r;
    r = $urandom_range(99);
    if (r < 8) add_byte(OP_END, 8'($urandom_range(255)));
    else if (r < 40) add_byte(OP_DATA, CH_SPACE);
    else if (r < 60) add_byte(OP_DATA, CH_TAB);
    else if (r < 80) add_byte(OP_DATA, CH_LF);
    else add_byte(OP_DATA, CH_CR);
  endfunction

  // A word may carry a leading zero, or stray characters that end the number early.
  function automatic void add_word(int unsigned value, bit blank);
    string      digits;
    logic [7:0] junk;
    if (!blank) begin
      if ($urandom_range(99) < 12) add_byte(OP_DATA, CH_ZERO);
      digits = $sformatf("%0d", value);
      for (int i = 0; i < digits.len(); i++) add_byte(OP_DATA, digits[i]);
      if ($urandom_range(99) < 10) begin
        do junk = 8'($urandom_range(255));
        while ((junk >= CH_ZERO && junk <= CH_NINE) || junk == CH_SPACE || junk == CH_TAB ||
               junk == CH_LF || junk == CH_CR);
        add_byte(OP_DATA, junk);
        add_byte(OP_DATA, 8'(CH_ZERO + $urandom_range(9)));
      end
    end
    add_separator();
  endfunction

  function automatic int unsigned pick_size(output bit blank);
    int r;
    blank = 1'b0;
    r     = $urandom_range(99);
    if (r < 68) return $urandom_range(1, 4);
    if (r < 76) return 0;
    if (r < 82) return MAX_DIM;
    if (r < 88) return MAX_DIM + 1;
    if (r < 93) return $urandom_range(65535, 999999);
    blank = 1'b1;
    return 0;
  endfunction

  function automatic void build_file();
    int unsigned w, h, mv, n_bytes, cut, keep;
    bit          wb, hb, mb, good;
    int          r;
    logic [7:0]  b;
    file_q.delete();
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(3, 12)) add_byte(2'($urandom_range(3)), 8'($urandom_range(255)));
      add_byte(OP_RESTART, 8'($urandom_range(255)));
      return;
    end
    if (r < 14) begin
      if ($urandom_range(1)) add_byte(OP_DATA, CH_P);
      if ($urandom_range(3) == 0) begin
        add_byte(OP_END, 8'($urandom_range(255)));
      end else begin
        do b = 8'($urandom_range(255));
        while (b == CH_SIX || b == CH_P);
        add_byte(OP_DATA, b);
      end
      repeat ($urandom_range(1, 4)) add_byte(OP_DATA, 8'($urandom_range(255)));
    end else begin
      add_byte(OP_DATA, CH_P);
      add_byte(OP_DATA, CH_SIX);
      if ($urandom_range(99) < 10) add_byte(OP_END, 8'($urandom_range(255)));
      else add_byte(OP_DATA, 8'($urandom_range(255)));
      w = pick_size(wb);
      add_word(w, wb);
      h = pick_size(hb);
      add_word(h, hb);
      mb = 1'b0;
      r  = $urandom_range(99);
      if (r < 82) mv = 255;
      else if (r < 96) mv = $urandom_range(300);
      else begin
        mv = 0;
        mb = 1'b1;
      end
      add_word(mv, mb);
      good = (mv == 255 && !mb && w <= MAX_DIM && h <= MAX_DIM);
      if (good) begin
        n_bytes = w * h * 3;
        if (n_bytes > 48) n_bytes = $urandom_range(1, 30);
        cut = ($urandom_range(99) < 15) ? $urandom_range(n_bytes) : n_bytes;
        for (int unsigned i = 0; i < n_bytes; i++) begin
          if ($urandom_range(99) < 4) add_byte(OP_UNUSED, 8'($urandom_range(255)));
          if (i >= cut || $urandom_range(99) < 5) add_byte(OP_END, 8'($urandom_range(255)));
          else add_byte(OP_DATA, 8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 30) begin
          repeat ($urandom_range(1, 3)) add_byte(OP_DATA, 8'($urandom_range(255)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) add_byte(2'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
    if ($urandom_range(99) < 10) begin
      keep = $urandom_range(file_q.size());
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
    add_byte(OP_RESTART, 8'($urandom_range(255)));
  endfunction

  task automatic send_item(logic [1:0] op, logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= op;
    do @(posedge clk);
    while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_item(file_q[i].op, file_q[i].data_byte);
  endtask

  task automatic run_files(int until_count);
    while (items_sent < until_count) begin
      build_file();
      send_file();
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // A 2x1 image with every separator kind, end of input inside the last pixel
    // and a trailing byte after the final pixel; then bad magic cases and op 3.
    file_q.delete();
    add_byte(OP_DATA, CH_P);
    add_byte(OP_DATA, CH_SIX);
    add_byte(OP_DATA, CH_LF);
    add_byte(OP_DATA, "2");
    add_byte(OP_DATA, CH_SPACE);
    add_byte(OP_DATA, "1");
    add_byte(OP_DATA, CH_TAB);
    add_byte(OP_DATA, "2");
    add_byte(OP_DATA, "5");
    add_byte(OP_DATA, "5");
    add_byte(OP_DATA, CH_CR);
    add_byte(OP_DATA, 8'h00);
    add_byte(OP_DATA, 8'hFF);
    add_byte(OP_DATA, 8'h80);
    add_byte(OP_DATA, 8'h01);
    add_byte(OP_END, 8'h00);
    add_byte(OP_END, 8'h00);
    add_byte(OP_DATA, 8'h7F);
    add_byte(OP_RESTART, 8'h00);
    add_byte(OP_DATA, "Q");
    add_byte(OP_DATA, CH_P);
    add_byte(OP_UNUSED, 8'hFF);
    add_byte(OP_RESTART, 8'h00);
    add_byte(OP_END, 8'h00);
    add_byte(OP_RESTART, 8'h00);
    send_file();

    tx_idle_pct = 30;
    rx_idle_pct = 85;
    hold_asked++;
    run_files(500);
    drain_results();

    tx_idle_pct = 85;
    rx_idle_pct = 30;
    run_files(980);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_asked++;
    run_files(1450);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (results_pending != 0) $display("%0d results never arrived", results_pending);
    if (check_failures == 0 && results_pending == 0) begin
      $display("ppm_p6_stream_parser_top_test OK");
    end else begin
      $display("ppm_p6_stream_parser_top_test NOT OK");
    end
    $finish;
  end

endmodule
